@@ design/ftl_pkg.sv @@
package ftl_pkg;

   localparam int AXES       = 6;
   localparam int FRAC_BITS  = 16;
   localparam int SAMPLE_W   = 32;
   localparam int STAMP_W    = 32;
   localparam int TC_W       = 24;
   localparam int DEN_W      = STAMP_W + 1;
   localparam int ALPHA_W    = FRAC_BITS + 1;
   localparam int PROD_W     = (ALPHA_W + 1) + (SAMPLE_W + 1);
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [TC_W-1:0]    TC_RESET  = TC_W'(1592);
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_CONSTANT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_BASE      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_END       = CSR_IDX_W'(2 + AXES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_START,
      ST_DIVIDE,
      ST_MULT,
      ST_UPDATE,
      ST_EMIT
   } ftl_state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic mult;
      logic update;
   } ftl_lane_cmd_type;

endpackage

@@ design/ftl_req_if.sv @@
interface ftl_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ftl_pkg::SAMPLE_W-1:0] raw_fx;
   logic signed [ftl_pkg::SAMPLE_W-1:0] raw_fy;
   logic signed [ftl_pkg::SAMPLE_W-1:0] raw_fz;
   logic signed [ftl_pkg::SAMPLE_W-1:0] raw_mx;
   logic signed [ftl_pkg::SAMPLE_W-1:0] raw_my;
   logic signed [ftl_pkg::SAMPLE_W-1:0] raw_mz;
   logic        [ftl_pkg::STAMP_W-1:0]  stamp_us;

   modport source (
      output valid, raw_fx, raw_fy, raw_fz, raw_mx, raw_my, raw_mz, stamp_us,
      input  ready
   );
   modport sink (
      input  valid, raw_fx, raw_fy, raw_fz, raw_mx, raw_my, raw_mz, stamp_us,
      output ready
   );
endinterface

@@ design/ftl_rsp_if.sv @@
interface ftl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ftl_pkg::SAMPLE_W-1:0] tared_fx;
   logic signed [ftl_pkg::SAMPLE_W-1:0] tared_fy;
   logic signed [ftl_pkg::SAMPLE_W-1:0] tared_fz;
   logic signed [ftl_pkg::SAMPLE_W-1:0] tared_mx;
   logic signed [ftl_pkg::SAMPLE_W-1:0] tared_my;
   logic signed [ftl_pkg::SAMPLE_W-1:0] tared_mz;
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_fx;
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_fy;
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_fz;
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_mx;
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_my;
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_mz;

   modport source (
      output valid, tared_fx, tared_fy, tared_fz, tared_mx, tared_my, tared_mz,
             smooth_fx, smooth_fy, smooth_fz, smooth_mx, smooth_my, smooth_mz,
      input  ready
   );
   modport sink (
      input  valid, tared_fx, tared_fy, tared_fz, tared_mx, tared_my, tared_mz,
             smooth_fx, smooth_fy, smooth_fz, smooth_mx, smooth_my, smooth_mz,
      output ready
   );
endinterface

@@ design/ftl_csr_if.sv @@
interface ftl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ftl_pkg::CSR_IDX_W-1:0]    index;
   logic [ftl_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (
      output valid, index, wdata,
      input  ready
   );
   modport sink (
      input  valid, index, wdata,
      output ready
   );
endinterface

@@ design/ftl_alpha_div.sv @@
// alpha = round(dt * 2^F / den), or one when den is zero; one quotient bit per cycle
module ftl_alpha_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ftl_pkg::STAMP_W-1:0]      dt,
   input  logic [ftl_pkg::DEN_W-1:0]        den,
   output logic                             done,
   output logic [ftl_pkg::ALPHA_W-1:0]      alpha
);

   localparam int NUM_W = ftl_pkg::DEN_W + ftl_pkg::FRAC_BITS;
   localparam int CNT_W = $clog2(ftl_pkg::ALPHA_W + 1);

   logic                          busy_ff, busy_in;
   logic                          prep_ff, prep_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [ftl_pkg::STAMP_W-1:0]   dt_ff;
   logic [ftl_pkg::DEN_W-1:0]     den_ff;
   logic [ftl_pkg::DEN_W-1:0]     rem_ff;
   logic [ftl_pkg::ALPHA_W-1:0]   low_ff;
   logic [ftl_pkg::ALPHA_W-1:0]   q_ff;

   logic [NUM_W-1:0]              num;
   logic [ftl_pkg::DEN_W:0]       trial;
   logic [ftl_pkg::DEN_W:0]       diff;
   logic                          q_bit;
   logic                          den_zero;

   // numerator includes den/2 so the truncating quotient rounds half up
   assign num = NUM_W'({dt_ff, {ftl_pkg::FRAC_BITS{1'b0}}}) + NUM_W'(den_ff >> 1);
   assign trial    = {rem_ff, low_ff[ftl_pkg::ALPHA_W-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign q_bit    = (trial >= {1'b0, den_ff});
   assign den_zero = (den_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      prep_in = prep_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         prep_in = 1'b1;
      end else if (busy_ff) begin
         if (prep_ff) begin
            prep_in = 1'b0;
            cnt_in  = CNT_W'(ftl_pkg::ALPHA_W);
            if (den_zero) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prep_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         prep_ff <= prep_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dt_ff  <= dt;
         den_ff <= den;
      end else if (busy_ff) begin
         if (prep_ff) begin
            if (den_zero) begin
               q_ff <= ftl_pkg::ALPHA_ONE;
            end else begin
               // top part is already below den since the quotient fits ALPHA_W bits
               rem_ff <= ftl_pkg::DEN_W'(num[NUM_W-1:ftl_pkg::ALPHA_W]);
               low_ff <= num[ftl_pkg::ALPHA_W-1:0];
               q_ff   <= '0;
            end
         end else begin
            rem_ff <= q_bit ? diff[ftl_pkg::DEN_W-1:0] : trial[ftl_pkg::DEN_W-1:0];
            low_ff <= {low_ff[ftl_pkg::ALPHA_W-2:0], 1'b0};
            q_ff   <= {q_ff[ftl_pkg::ALPHA_W-2:0], q_bit};
         end
      end
   end

   assign done  = done_ff;
   assign alpha = q_ff;

endmodule

@@ design/ftl_lane.sv @@
// one axis: bias removal and the lowpass update
module ftl_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ftl_pkg::ftl_lane_cmd_type            cmd,
   input  logic signed [ftl_pkg::SAMPLE_W-1:0]  raw,
   input  logic                                 bias_we,
   input  logic [ftl_pkg::CSR_DATA_W-1:0]       bias_wdata,
   input  logic [ftl_pkg::ALPHA_W-1:0]          alpha,
   output logic signed [ftl_pkg::SAMPLE_W-1:0]  tared,
   output logic signed [ftl_pkg::SAMPLE_W-1:0]  smooth
);

   localparam int SW = ftl_pkg::SAMPLE_W;
   localparam int PW = ftl_pkg::PROD_W;
   localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [PW-1:0] HALF_LSB =
      {{(PW-ftl_pkg::FRAC_BITS){1'b0}}, 1'b1, {(ftl_pkg::FRAC_BITS-1){1'b0}}};

   logic signed [SW-1:0]  bias_ff;
   logic signed [SW-1:0]  tared_ff, tared_in;
   logic signed [SW-1:0]  smooth_ff, smooth_in;
   logic signed [PW-1:0]  prod_ff, prod_in;

   logic signed [SW:0]                   diff;
   logic signed [SW:0]                   err;
   logic signed [ftl_pkg::ALPHA_W:0]     alpha_s;
   logic signed [PW-1:0]                 rnd;
   logic signed [PW-1:0]                 delta;
   logic signed [PW-1:0]                 sum;

   assign diff     = {raw[SW-1], raw} - {bias_ff[SW-1], bias_ff};
   assign tared_in = (diff[SW] != diff[SW-1]) ? (diff[SW] ? SAT_MIN : SAT_MAX)
                                              : diff[SW-1:0];

   assign err     = {tared_ff[SW-1], tared_ff} - {smooth_ff[SW-1], smooth_ff};
   assign alpha_s = {1'b0, alpha};
   assign prod_in = alpha_s * err;

   // floor of (p + half) / 2^F: arithmetic shift rounds toward minus infinity
   assign rnd   = prod_ff + HALF_LSB;
   assign delta = rnd >>> ftl_pkg::FRAC_BITS;
   assign sum   = delta + {{(PW-SW){smooth_ff[SW-1]}}, smooth_ff};

   always_comb begin
      smooth_in = smooth_ff;
      if (cmd.load) begin
         smooth_in = tared_ff;
      end else if (cmd.update) begin
         if ((&sum[PW-1:SW-1]) || !(|sum[PW-1:SW-1])) begin
            smooth_in = sum[SW-1:0];
         end else begin
            smooth_in = sum[PW-1] ? SAT_MIN : SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= '0;
         smooth_ff <= '0;
      end else begin
         if (bias_we) begin
            bias_ff <= bias_wdata;
         end
         smooth_ff <= smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tared_ff <= tared_in;
      end
      if (cmd.mult) begin
         prod_ff <= prod_in;
      end
   end

   assign tared  = tared_ff;
   assign smooth = smooth_ff;

endmodule

@@ design/force_tare_lowpass.sv @@
// Frames that only load the filter pass LOAD; with the lowpass running they pass START, DIVIDE,
//   MULT and UPDATE (the divider skips its steps when time constant and dt are both zero).
// Both paths end in EMIT. A frame is taken only in IDLE; DIVIDE runs the 17-step alpha divider.
//   A waiting result does not block the next accept.
// Reset: lowpass off, time constant 1592 us, biases and state cleared, filter uninitialised.
module force_tare_lowpass (
   input  logic       clock,
   input  logic       reset,
   ftl_req_if.sink    req_ch,
   ftl_rsp_if.source  rsp_ch,
   ftl_csr_if.sink    csr_ch
);

   localparam int AX = ftl_pkg::AXES;
   localparam int SW = ftl_pkg::SAMPLE_W;

   ftl_pkg::ftl_state_type      state_ff, state_in;
   ftl_pkg::ftl_lane_cmd_type   lane_cmd;

   logic                          enable_ff;
   logic [ftl_pkg::TC_W-1:0]      tc_ff;
   logic                          filt_ready_ff, filt_ready_in;
   logic [ftl_pkg::STAMP_W-1:0]   last_stamp_ff;
   logic [ftl_pkg::STAMP_W-1:0]   stamp_ff;
   logic [ftl_pkg::STAMP_W-1:0]   dt_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]          tared_out_ff [AX];
   logic signed [SW-1:0]          smooth_out_ff [AX];

   logic                          req_accept;
   logic                          csr_we;
   logic                          bias_hit;
   logic                          div_start;
   logic                          div_done;
   logic [ftl_pkg::ALPHA_W-1:0]   div_alpha;
   logic [ftl_pkg::DEN_W-1:0]     den;
   logic                          emit_go;
   logic                          in_idle;

   logic signed [SW-1:0]          raw_lane [AX];
   logic signed [SW-1:0]          tared_lane [AX];
   logic signed [SW-1:0]          smooth_lane [AX];

   assign raw_lane[0] = req_ch.raw_fx;
   assign raw_lane[1] = req_ch.raw_fy;
   assign raw_lane[2] = req_ch.raw_fz;
   assign raw_lane[3] = req_ch.raw_mx;
   assign raw_lane[4] = req_ch.raw_my;
   assign raw_lane[5] = req_ch.raw_mz;

   // ---- configuration ----
   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid & csr_ch.ready;
   assign bias_hit     = csr_we && (csr_ch.index >= ftl_pkg::CSR_BIAS_BASE)
                                && (csr_ch.index <  ftl_pkg::CSR_BIAS_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         tc_ff     <= ftl_pkg::TC_RESET;
      end else if (csr_we) begin
         if (csr_ch.index == ftl_pkg::CSR_LOWPASS_ENABLE) begin
            enable_ff <= csr_ch.wdata[0];
         end else if (csr_ch.index == ftl_pkg::CSR_TIME_CONSTANT) begin
            tc_ff <= csr_ch.wdata[ftl_pkg::TC_W-1:0];
         end
      end
   end

   // ---- sequencer ----
   assign in_idle    = (state_ff == ftl_pkg::ST_IDLE);
   assign req_accept = req_ch.valid & req_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftl_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (enable_ff && filt_ready_ff) ? ftl_pkg::ST_START : ftl_pkg::ST_LOAD;
            end
         end
         ftl_pkg::ST_LOAD:   state_in = ftl_pkg::ST_EMIT;
         ftl_pkg::ST_START:  state_in = ftl_pkg::ST_DIVIDE;
         ftl_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = ftl_pkg::ST_MULT;
            end
         end
         ftl_pkg::ST_MULT:   state_in = ftl_pkg::ST_UPDATE;
         ftl_pkg::ST_UPDATE: state_in = ftl_pkg::ST_EMIT;
         ftl_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ftl_pkg::ST_IDLE;
            end
         end
         default: state_in = ftl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready     = in_idle;
      lane_cmd.capture = in_idle && req_ch.valid;
      lane_cmd.load    = (state_ff == ftl_pkg::ST_LOAD);
      lane_cmd.mult    = (state_ff == ftl_pkg::ST_MULT);
      lane_cmd.update  = (state_ff == ftl_pkg::ST_UPDATE);
      div_start        = (state_ff == ftl_pkg::ST_START);
      emit_go          = (state_ff == ftl_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   end

   // a bias write forces the next frame to reload the filter
   always_comb begin
      filt_ready_in = filt_ready_ff;
      if (bias_hit) begin
         filt_ready_in = 1'b0;
      end else if (lane_cmd.load) begin
         filt_ready_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ftl_pkg::ST_IDLE;
         filt_ready_ff <= 1'b0;
         last_stamp_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         filt_ready_ff <= filt_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (emit_go) begin
            last_stamp_ff <= stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stamp_ff <= req_ch.stamp_us;
         dt_ff    <= req_ch.stamp_us - last_stamp_ff;
      end
   end

   assign den = ftl_pkg::DEN_W'(dt_ff) + ftl_pkg::DEN_W'(tc_ff);

   ftl_alpha_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dt    (dt_ff),
      .den   (den),
      .done  (div_done),
      .alpha (div_alpha)
   );

   // ---- axis lanes ----
   for (genvar i = 0; i < AX; i++) begin : g_lane
      logic bias_we;
      assign bias_we = csr_we
                    && (csr_ch.index == ftl_pkg::CSR_BIAS_BASE + ftl_pkg::CSR_IDX_W'(i));

      ftl_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (lane_cmd),
         .raw        (raw_lane[i]),
         .bias_we    (bias_we),
         .bias_wdata (csr_ch.wdata),
         .alpha      (div_alpha),
         .tared      (tared_lane[i]),
         .smooth     (smooth_lane[i])
      );
   end

   // ---- result register: gathers all lanes into one transfer ----
   always_ff @(posedge clock) begin
      if (emit_go) begin
         for (int k = 0; k < AX; k++) begin
            tared_out_ff[k]  <= tared_lane[k];
            smooth_out_ff[k] <= smooth_lane[k];
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.tared_fx  = tared_out_ff[0];
   assign rsp_ch.tared_fy  = tared_out_ff[1];
   assign rsp_ch.tared_fz  = tared_out_ff[2];
   assign rsp_ch.tared_mx  = tared_out_ff[3];
   assign rsp_ch.tared_my  = tared_out_ff[4];
   assign rsp_ch.tared_mz  = tared_out_ff[5];
   assign rsp_ch.smooth_fx = smooth_out_ff[0];
   assign rsp_ch.smooth_fy = smooth_out_ff[1];
   assign rsp_ch.smooth_fz = smooth_out_ff[2];
   assign rsp_ch.smooth_mx = smooth_out_ff[3];
   assign rsp_ch.smooth_my = smooth_out_ff[4];
   assign rsp_ch.smooth_mz = smooth_out_ff[5];

   // ---- checks ----
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ftl_pkg::ST_DIVIDE))
      else $error("divider finished outside the divide phase");

   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ftl_pkg::ST_LOAD || state_ff == ftl_pkg::ST_START))
      else $error("accepted frame did not start processing");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ftl_pkg::ST_MULT) |-> (div_alpha <= ftl_pkg::ALPHA_ONE))
      else $error("alpha above one");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule

@@ verif/force_tare_lowpass_tb.sv @@
`timescale 1ns / 100ps

module force_tare_lowpass_tb;

   localparam int      CYCLE_LIMIT     = 1_000_000;
   localparam int      HOLD_OFF_CYCLES = 300;
   localparam int      DRAIN_CYCLES    = 30;
   localparam int      FAIL_REPORTS    = 10;
   localparam int      STREAM_PHASES   = 8;
   localparam int      PHASE_FRAMES    = 175;
   localparam longint  SAMPLE_HI       = 64'sd2147483647;
   localparam longint  SAMPLE_LO       = -64'sd2147483648;

   localparam logic [ftl_pkg::SAMPLE_W-1:0]  S_MAX        = 32'h7FFF_FFFF;
   localparam logic [ftl_pkg::SAMPLE_W-1:0]  S_MIN        = 32'h8000_0000;
   localparam logic [ftl_pkg::TC_W-1:0]      TC_MAX       = '1;
   localparam logic [ftl_pkg::CSR_IDX_W-1:0] CSR_IDX_LAST = '1;

   typedef struct packed {
      logic [ftl_pkg::AXES-1:0][ftl_pkg::SAMPLE_W-1:0] raw;
      logic [ftl_pkg::STAMP_W-1:0]                     stamp;
   } frame_type;

   typedef struct packed {
      logic [ftl_pkg::AXES-1:0][ftl_pkg::SAMPLE_W-1:0] tared;
      logic [ftl_pkg::AXES-1:0][ftl_pkg::SAMPLE_W-1:0] smooth;
   } wrench_type;

   logic clock = 1'b0;
   logic reset;

   ftl_req_if req_ch ();
   ftl_rsp_if rsp_ch ();
   ftl_csr_if csr_ch ();

   force_tare_lowpass dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // filter model
   logic                                lp_enable_model = 1'b0;
   logic [ftl_pkg::TC_W-1:0]            tc_model        = ftl_pkg::TC_RESET;
   logic signed [ftl_pkg::SAMPLE_W-1:0] bias_model   [ftl_pkg::AXES] = '{default: '0};
   logic signed [ftl_pkg::SAMPLE_W-1:0] smooth_model [ftl_pkg::AXES] = '{default: '0};
   logic [ftl_pkg::STAMP_W-1:0]         last_stamp_model = '0;
   logic                                filter_primed    = 1'b0;

   wrench_type wrench_expected [$];

   string axis_name [ftl_pkg::AXES] = '{"fx", "fy", "fz", "mx", "my", "mz"};

   int failures        = 0;
   int results_seen    = 0;
   int frames_sent     = 0;
   int filtered_frames = 0;
   int reg_writes      = 0;
   int cycle_count     = 0;
   int holdoffs_asked  = 0;
   int holdoffs_done   = 0;

   // sender idling
   int gap_max    = 4;
   int burst_max  = 6;
   int burst_left = 0;

   // slow drift for well-formed streams
   int                          wrench_level [ftl_pkg::AXES] = '{default: 0};
   logic [ftl_pkg::STAMP_W-1:0] stream_stamp = '0;

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= FAIL_REPORTS)
         $display("%s", msg);
   endfunction

   function automatic logic [ftl_pkg::SAMPLE_W-1:0] clamp_sample(input longint v);
      if (v > SAMPLE_HI)
         return S_MAX;
      if (v < SAMPLE_LO)
         return S_MIN;
      return v[ftl_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic void apply_csr(input logic [ftl_pkg::CSR_IDX_W-1:0]  idx,
                                     input logic [ftl_pkg::CSR_DATA_W-1:0] val);
      if (idx == ftl_pkg::CSR_LOWPASS_ENABLE) begin
         lp_enable_model = val[0];
      end else if (idx == ftl_pkg::CSR_TIME_CONSTANT) begin
         tc_model = val[ftl_pkg::TC_W-1:0];
      end else if (idx >= ftl_pkg::CSR_BIAS_BASE && idx < ftl_pkg::CSR_BIAS_END) begin
         bias_model[idx - ftl_pkg::CSR_BIAS_BASE] = val;
         filter_primed = 1'b0;
      end
      reg_writes++;
   endfunction

   function automatic wrench_type predict_wrench(input frame_type f);
      wrench_type                  w;
      logic [ftl_pkg::STAMP_W-1:0] dt;
      logic [63:0]                 den;
      logic [63:0]                 alpha;
      longint                      err;
      longint                      delta;
      for (int i = 0; i < ftl_pkg::AXES; i++)
         w.tared[i] = clamp_sample(longint'($signed(f.raw[i])) - longint'(bias_model[i]));
      if (!lp_enable_model || !filter_primed) begin
         for (int i = 0; i < ftl_pkg::AXES; i++)
            smooth_model[i] = w.tared[i];
         filter_primed = 1'b1;
      end else begin
         dt  = f.stamp - last_stamp_model;
         den = 64'(tc_model) + 64'(dt);
         if (den == 0)
            alpha = 64'(1) << ftl_pkg::FRAC_BITS;
         else
            alpha = ((64'(dt) << ftl_pkg::FRAC_BITS) + (den >> 1)) / den;
         for (int i = 0; i < ftl_pkg::AXES; i++) begin
            err   = longint'($signed(w.tared[i])) - longint'(smooth_model[i]);
            // floor after adding half an lsb: ties go towards +inf
            delta = (longint'(alpha) * err + (longint'(1) << (ftl_pkg::FRAC_BITS - 1)))
                    >>> ftl_pkg::FRAC_BITS;
            smooth_model[i] = clamp_sample(longint'(smooth_model[i]) + delta);
         end
         filtered_frames++;
      end
      last_stamp_model = f.stamp;
      for (int i = 0; i < ftl_pkg::AXES; i++)
         w.smooth[i] = smooth_model[i];
      return w;
   endfunction

   function automatic void compare_wrench(input wrench_type want, input wrench_type got);
      for (int i = 0; i < ftl_pkg::AXES; i++) begin
         if (got.tared[i] !== want.tared[i])
            note_failure($sformatf("result %0d tared_%s: expected %0d, got %0d", results_seen,
               axis_name[i], $signed(want.tared[i]), $signed(got.tared[i])));
         if (got.smooth[i] !== want.smooth[i])
            note_failure($sformatf("result %0d smooth_%s: expected %0d, got %0d", results_seen,
               axis_name[i], $signed(want.smooth[i]), $signed(got.smooth[i])));
      end
   endfunction

   // transfers on all three channels, sampled at the edge
   always @(posedge clock) begin : monitor
      wrench_type got;
      frame_type  bus_frame;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.tared  = {rsp_ch.tared_mz, rsp_ch.tared_my, rsp_ch.tared_mx,
                          rsp_ch.tared_fz, rsp_ch.tared_fy, rsp_ch.tared_fx};
            got.smooth = {rsp_ch.smooth_mz, rsp_ch.smooth_my, rsp_ch.smooth_mx,
                          rsp_ch.smooth_fz, rsp_ch.smooth_fy, rsp_ch.smooth_fx};
            results_seen++;
            if (wrench_expected.size() == 0)
               note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            else
               compare_wrench(wrench_expected.pop_front(), got);
         end
         if (csr_ch.valid && csr_ch.ready)
            apply_csr(csr_ch.index, csr_ch.wdata);
         if (req_ch.valid && req_ch.ready) begin
            bus_frame.raw   = {req_ch.raw_mz, req_ch.raw_my, req_ch.raw_mx,
                               req_ch.raw_fz, req_ch.raw_fy, req_ch.raw_fx};
            bus_frame.stamp = req_ch.stamp_us;
            wrench_expected.push_back(predict_wrench(bus_frame));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
            wrench_expected.size());
         $display("force_tare_lowpass_tb: errors");
         $finish;
      end
   end

   // result side: changing ready density, plus long hold-offs on request
   initial begin : result_stalls
      int pct;
      int left;
      int hold;
      pct  = 100;
      left = 0;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoffs_done != holdoffs_asked) begin
            hold = HOLD_OFF_CYCLES;
            holdoffs_done++;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1:    pct = 100;
                  2:       pct = 70;
                  3:       pct = 40;
                  default: pct = 10;
               endcase
               left = $urandom_range(32, 256);
            end
            left--;
            rsp_ch.ready <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   function automatic frame_type frame_of(input logic [ftl_pkg::SAMPLE_W-1:0] fx, fy, fz,
                                          mx, my, mz,
                                          input logic [ftl_pkg::STAMP_W-1:0] stamp);
      frame_type f;
      f.raw   = {mz, my, mx, fz, fy, fx};
      f.stamp = stamp;
      return f;
   endfunction

   function automatic frame_type random_frame(input logic [ftl_pkg::STAMP_W-1:0] stamp);
      frame_type f;
      for (int i = 0; i < ftl_pkg::AXES; i++)
         f.raw[i] = $urandom;
      f.stamp = stamp;
      return f;
   endfunction

   task automatic send_frame(input frame_type f);
      req_ch.valid    <= 1'b1;
      req_ch.raw_fx   <= f.raw[0];
      req_ch.raw_fy   <= f.raw[1];
      req_ch.raw_fz   <= f.raw[2];
      req_ch.raw_mx   <= f.raw[3];
      req_ch.raw_my   <= f.raw[4];
      req_ch.raw_mz   <= f.raw[5];
      req_ch.stamp_us <= f.stamp;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      frames_sent++;
      if (burst_left > 0 || gap_max == 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(0, burst_max);
      end
   endtask

   // keep_valid lets a run of writes go back to back
   task automatic write_reg(input logic [ftl_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [ftl_pkg::CSR_DATA_W-1:0] val,
                            input bit keep_valid = 1'b0);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= val;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      if (!keep_valid)
         csr_ch.valid <= 1'b0;
   endtask

   task automatic write_biases(input logic [ftl_pkg::SAMPLE_W-1:0] b [ftl_pkg::AXES]);
      for (int i = 0; i < ftl_pkg::AXES; i++)
         write_reg(ftl_pkg::CSR_IDX_W'(ftl_pkg::CSR_BIAS_BASE + i), b[i],
                   i != ftl_pkg::AXES - 1);
   endtask

   // block is idle once every frame taken has come back
   task automatic settle();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (wrench_expected.size() != 0);
   endtask

   task automatic stream_frames(input int count, input int noise_pct);
      frame_type                   f;
      logic [ftl_pkg::STAMP_W-1:0] dt;
      int                          pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            f = random_frame($urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               dt = '0;
            else if (pick < 80)
               dt = $urandom_range(900, 1100);
            else if (pick < 90)
               dt = $urandom_range(1, 60);
            else if (pick < 98)
               dt = $urandom_range(2000, 2_000_000);
            else
               dt = $urandom;
            stream_stamp += dt;
            for (int i = 0; i < ftl_pkg::AXES; i++) begin
               wrench_level[i] += int'($urandom_range(0, 131072)) - 65536;
               f.raw[i] = wrench_level[i] + int'($urandom_range(0, 4095)) - 2048;
            end
            f.stamp = stream_stamp;
         end
         send_frame(f);
      end
   endtask

   task automatic test_passthrough_after_reset();
      send_frame(frame_of(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 32'hFFFF_FFFF));
      send_frame(frame_of(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 32'h0000_0000));
      send_frame(frame_of(32'h0, 32'hFFFF_FFFF, 32'h1, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h0001_0000, 32'h8000_0000));
   endtask

   task automatic test_bias_saturation();
      logic [ftl_pkg::SAMPLE_W-1:0] b [ftl_pkg::AXES];
      b = '{S_MIN, S_MAX, 32'hFFFF_FFFF, 32'h1, S_MIN, S_MAX};
      settle();
      write_biases(b);
      send_frame(frame_of(S_MAX, S_MIN, S_MAX, S_MIN, 32'h0, 32'h0, 32'h10));
      send_frame(frame_of(S_MIN, S_MAX, 32'hFFFF_FFFF, 32'h1, 32'h5, 32'hFFFF_FFFB, 32'h20));
      send_frame(frame_of(32'hFFFF_FFFF, 32'h0, S_MIN, S_MAX, S_MIN, S_MIN, 32'h30));
   endtask

   task automatic test_lowpass_steps();
      logic [ftl_pkg::SAMPLE_W-1:0] b [ftl_pkg::AXES];
      b = '{default: '0};
      settle();
      write_reg(ftl_pkg::CSR_LOWPASS_ENABLE, 32'h1, 1'b1);
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, ftl_pkg::CSR_DATA_W'(ftl_pkg::TC_RESET), 1'b1);
      write_biases(b);
      send_frame(frame_of(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd1000));
      send_frame(frame_of(S_MAX, S_MIN, 32'h0001_0000, 32'hFFFF_0000, 32'd12345,
                          32'hFFFF_FFFF, 32'd2000));
      // no time elapsed: the smoothed values do not move
      send_frame(random_frame(32'd2000));
      send_frame(frame_of(S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, 32'hFFFF_FFF0));
      // stamp wraps
      send_frame(random_frame(32'h0000_0100));
      send_frame(frame_of(S_MAX, S_MIN, S_MAX, S_MIN, 32'h0, 32'h0, 32'h0000_0101));
      settle();
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, ftl_pkg::CSR_DATA_W'(TC_MAX));
      send_frame(frame_of(S_MIN, S_MAX, 32'h0, 32'h0, S_MAX, S_MIN, 32'h0000_0102));
      send_frame(random_frame(32'h0000_0101));
      // zero time constant with zero dt: alpha saturates to one
      settle();
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, 32'h0);
      send_frame(random_frame(32'h0000_0101));
      send_frame(frame_of(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0104));
      // alpha of one half: odd errors land on rounding ties
      settle();
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, 32'h1);
      send_frame(frame_of(32'h1, 32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFD, S_MAX, S_MIN,
                          32'h0000_0105));
   endtask

   task automatic test_bias_write_reinit();
      settle();
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, ftl_pkg::CSR_DATA_W'(ftl_pkg::TC_RESET));
      send_frame(random_frame(32'h0000_0500));
      settle();
      write_reg(ftl_pkg::CSR_IDX_W'(ftl_pkg::CSR_BIAS_BASE + 4), $urandom);
      send_frame(random_frame(32'h0000_0900));
      send_frame(random_frame(32'h0000_0D00));
      settle();
      write_reg(ftl_pkg::CSR_LOWPASS_ENABLE, 32'h0);
      send_frame(random_frame(32'h0000_1100));
   endtask

   task automatic test_register_corners();
      settle();
      write_reg(ftl_pkg::CSR_LOWPASS_ENABLE, 32'hFFFF_FFFE);
      send_frame(random_frame(32'h0000_1500));
      settle();
      write_reg(ftl_pkg::CSR_LOWPASS_ENABLE, 32'hFFFF_FFFF, 1'b1);
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, 32'hFF00_0010, 1'b1);
      write_reg(ftl_pkg::CSR_BIAS_END, $urandom, 1'b1);
      write_reg(CSR_IDX_LAST, $urandom);
      send_frame(random_frame(32'h0000_1520));
      send_frame(random_frame(32'h0000_1523));
   endtask

   task automatic test_output_holdoff();
      settle();
      write_reg(ftl_pkg::CSR_LOWPASS_ENABLE, 32'h1, 1'b1);
      write_reg(ftl_pkg::CSR_TIME_CONSTANT, 32'd200);
      gap_max = 0;
      holdoffs_asked++;
      stream_frames(30, 0);
   endtask

   task automatic test_random_streams();
      logic [ftl_pkg::SAMPLE_W-1:0] b [ftl_pkg::AXES];
      logic [31:0]                  word;
      logic [ftl_pkg::TC_W-1:0]     tc;
      for (int p = 0; p < STREAM_PHASES; p++) begin
         settle();
         gap_max   = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 25;
         burst_max = (p % 2 == 0) ? 4 : 20;
         word      = $urandom;
         word[0]   = (p != 0) && ($urandom_range(0, 9) != 0);
         write_reg(ftl_pkg::CSR_LOWPASS_ENABLE, word, 1'b1);
         case (p % 4)
            0:       tc = 24'd1;
            1:       tc = TC_MAX;
            2:       tc = $urandom_range(200, 5000);
            default: tc = $urandom_range(1, TC_MAX);
         endcase
         write_reg(ftl_pkg::CSR_TIME_CONSTANT, {8'($urandom), tc}, 1'b1);
         for (int i = 0; i < ftl_pkg::AXES; i++) begin
            wrench_level[i] = (p % 4 == 3) ? int'($urandom)
                                           : int'($urandom_range(0, 1 << 25)) - (1 << 24);
            b[i] = ($urandom_range(0, 9) < 7)
                   ? wrench_level[i] + int'($urandom_range(0, 1 << 21)) - (1 << 20)
                   : $urandom;
         end
         write_biases(b);
         stream_frames(PHASE_FRAMES / 2, 10);
         if ($urandom_range(0, 1)) begin
            settle();
            write_reg(ftl_pkg::CSR_IDX_W'($urandom_range(0, 15)), $urandom);
         end
         stream_frames(PHASE_FRAMES - PHASE_FRAMES / 2, 10);
      end
   endtask

   task automatic finish_run();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (wrench_expected.size() != 0)
         note_failure($sformatf("%0d results never arrived", wrench_expected.size()));
      $display("summary: %0d frames sent (%0d through the lowpass), %0d register writes",
         frames_sent, filtered_frames, reg_writes);
      $display("summary: %0d results checked, %0d failures", results_seen, failures);
      if (failures == 0)
         $display("force_tare_lowpass_tb: clean");
      else
         $display("force_tare_lowpass_tb: errors");
      $finish;
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.raw_fx   <= '0;
      req_ch.raw_fy   <= '0;
      req_ch.raw_fz   <= '0;
      req_ch.raw_mx   <= '0;
      req_ch.raw_my   <= '0;
      req_ch.raw_mz   <= '0;
      req_ch.stamp_us <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.wdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough_after_reset();
      test_bias_saturation();
      test_lowpass_steps();
      test_bias_write_reinit();
      test_register_corners();
      test_output_holdoff();
      test_random_streams();
      finish_run();
   end

endmodule
